[rtl/olab_pkg.sv]
package olab_pkg;

    // Ring geometry (the ring length must stay a power of two)
    localparam int LENGTH    = 4096;
    localparam int ADDR_W    = $clog2(LENGTH);
    localparam int CLR_W     = ADDR_W + 1;

    // Field widths
    localparam int ACC_W     = 24;
    localparam int SAMPLE_W  = 16;
    localparam int HOP_W     = 13;
    localparam int OFS_W     = 17;
    localparam int SUM_W     = OFS_W + 1;
    localparam int FIDX_W    = 13;
    localparam int TIME_W    = 32;
    localparam int THR_W     = 16;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // Saturation limits
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [OFS_W-1:0] OFS_MAX = {1'b0, {(OFS_W-1){1'b1}}};
    localparam logic signed [OFS_W-1:0] OFS_MIN = {1'b1, {(OFS_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_END = 2'd1,
        OP_POP = 2'd2,
        OP_NOP = 2'd3
    } op_t;

    // Request issued to the accumulator datapath
    typedef struct packed {
        op_t                        op;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       filled;
        logic [TIME_W-1:0]          time_count;
    } issue_t;

    // One result item
    typedef struct packed {
        logic signed [ACC_W-1:0] sample_out;
        logic                    sample_valid;
        logic                    filled;
        logic [TIME_W-1:0]       time_count;
    } result_t;

endpackage

[rtl/overlap_add_ring_buffer.sv]
// A request's result is registered in the datapath stage and then in the result queue before it shows on m_tvalid.
// Throughput: one request per cycle; the memory read-modify-write with a one-entry bypass
//   sets this, and s_tready drops only when the four-entry result queue would fill or while clearing.
// Reset: rst_n clears all control state; a clearing pass then writes zero to the 4096
//   accumulator entries, one per cycle, with s_tready low throughout the pass.
module overlap_add_ring_buffer (
    input  logic                              clk,
    input  logic                              rst_n,
    // [15:0] sample_in, [28:16] hop_period, [31:29] zero
    input  logic [31:0]                       s_tdata,
    // [1:0] operation
    input  logic [1:0]                        s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [23:0] sample_out, [24] filled, [56:25] time_count, [63:57] zero
    output logic [63:0]                       m_tdata,
    // [0] sample_valid
    output logic                              m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_wr_en,
    input  logic [olab_pkg::THR_W-1:0]        cfg_wr_data
);

    logic                                  accept;
    logic                                  clear_busy;
    logic                                  res_valid;
    olab_pkg::issue_t                      issue;
    olab_pkg::result_t                     res;
    olab_pkg::result_t                     head;
    logic [olab_pkg::FIFO_CNT_W-1:0]       fifo_cnt;
    logic [olab_pkg::FIFO_CNT_W:0]         inflight;

    // Admission: queue plus the item in the datapath stage must leave room
    always_comb
    begin
        inflight = {1'b0, fifo_cnt} + (olab_pkg::FIFO_CNT_W+1)'(res_valid);
        s_tready = !clear_busy
                && (inflight < (olab_pkg::FIFO_CNT_W+1)'(olab_pkg::FIFO_DEPTH));
        accept   = s_tvalid && s_tready;
    end

    olab_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .op          (olab_pkg::op_t'(s_tuser)),
        .sample_in   (s_tdata[15:0]),
        .hop_period  (s_tdata[28:16]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .issue       (issue)
    );

    olab_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue_valid (accept),
        .issue       (issue),
        .clear_busy  (clear_busy),
        .res_valid   (res_valid),
        .res         (res)
    );

    olab_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (m_tready),
        .not_empty (m_tvalid),
        .head      (head),
        .count     (fifo_cnt)
    );

    // Output packing
    assign m_tdata = {7'd0, head.time_count, head.filled, head.sample_out};
    assign m_tuser = head.sample_valid;

endmodule

[rtl/olab_ctrl.sv]
module olab_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  olab_pkg::op_t                        op,
    input  logic signed [olab_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [olab_pkg::HOP_W-1:0]           hop_period,
    input  logic                                 cfg_wr_en,
    input  logic [olab_pkg::THR_W-1:0]           cfg_wr_data,
    output olab_pkg::issue_t                     issue
);

    logic [olab_pkg::ADDR_W-1:0]        rp_reg,   rp_next;
    logic signed [olab_pkg::OFS_W-1:0]  wo_reg,   wo_next;
    logic [olab_pkg::FIDX_W-1:0]        fi_reg,   fi_next;
    logic [olab_pkg::TIME_W-1:0]        time_reg, time_next;
    logic [olab_pkg::THR_W-1:0]         thr_reg;

    logic [olab_pkg::SUM_W-1:0]  addr_sum;
    logic [olab_pkg::ADDR_W-1:0] acc_addr;
    logic [olab_pkg::SUM_W-1:0]  ofs_adv;
    logic [olab_pkg::SUM_W-1:0]  ofs_dec;

    // Ring address of the next frame sample: modulo by truncation
    always_comb
    begin
        addr_sum = {{(olab_pkg::SUM_W-olab_pkg::ADDR_W){1'b0}}, rp_reg}
                 + {wo_reg[olab_pkg::OFS_W-1], wo_reg}
                 + {{(olab_pkg::SUM_W-olab_pkg::FIDX_W){1'b0}}, fi_reg};
        acc_addr = addr_sum[olab_pkg::ADDR_W-1:0];
    end

    // Offset arithmetic, one guard bit for saturation
    always_comb
    begin
        ofs_adv = {wo_reg[olab_pkg::OFS_W-1], wo_reg}
                + {{(olab_pkg::SUM_W-olab_pkg::HOP_W){1'b0}}, hop_period};
        ofs_dec = {wo_reg[olab_pkg::OFS_W-1], wo_reg} - olab_pkg::SUM_W'(1);
    end

    // State update for the accepted request
    always_comb
    begin
        rp_next   = rp_reg;
        wo_next   = wo_reg;
        fi_next   = fi_reg;
        time_next = time_reg;
        if (accept)
        begin
            case (op)
                olab_pkg::OP_ADD:
                begin
                    fi_next = fi_reg + olab_pkg::FIDX_W'(1);
                end
                olab_pkg::OP_END:
                begin
                    fi_next   = '0;
                    time_next = time_reg
                              + {{(olab_pkg::TIME_W-olab_pkg::HOP_W){1'b0}}, hop_period};
                    if (ofs_adv[olab_pkg::SUM_W-1:olab_pkg::SUM_W-2] == 2'b01)
                        wo_next = olab_pkg::OFS_MAX;
                    else
                        wo_next = ofs_adv[olab_pkg::OFS_W-1:0];
                end
                olab_pkg::OP_POP:
                begin
                    rp_next = rp_reg + olab_pkg::ADDR_W'(1);
                    if (ofs_dec[olab_pkg::SUM_W-1:olab_pkg::SUM_W-2] == 2'b10)
                        wo_next = olab_pkg::OFS_MIN;
                    else
                        wo_next = ofs_dec[olab_pkg::OFS_W-1:0];
                end
                default:
                begin
                    rp_next = rp_reg;
                end
            endcase
        end
    end

    // Request to the datapath, flags reflect the updated state
    always_comb
    begin
        issue.op         = op;
        issue.addr       = (op == olab_pkg::OP_POP) ? rp_reg : acc_addr;
        issue.sample     = sample_in;
        issue.filled     = (wo_next > $signed({1'b0, thr_reg}));
        issue.time_count = time_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg   <= '0;
            wo_reg   <= '0;
            fi_reg   <= '0;
            time_reg <= '0;
            thr_reg  <= '0;
        end
        else
        begin
            rp_reg   <= rp_next;
            wo_reg   <= wo_next;
            fi_reg   <= fi_next;
            time_reg <= time_next;
            if (cfg_wr_en)
                thr_reg <= cfg_wr_data;
        end
    end

endmodule

[rtl/olab_dp.sv]
module olab_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              issue_valid,
    input  olab_pkg::issue_t  issue,
    output logic              clear_busy,
    output logic              res_valid,
    output olab_pkg::result_t res
);

    logic signed [olab_pkg::ACC_W-1:0] acc_mem [olab_pkg::LENGTH];

    logic                              clr_busy_reg;
    logic [olab_pkg::CLR_W-1:0]        clr_addr_reg;

    logic                              s1_valid_reg;
    olab_pkg::issue_t                  s1_reg;
    logic signed [olab_pkg::ACC_W-1:0] rd_reg;
    logic                              fwd_hit_reg;
    logic signed [olab_pkg::ACC_W-1:0] fwd_data_reg;

    logic signed [olab_pkg::ACC_W-1:0] cur_val;
    logic signed [olab_pkg::ACC_W:0]   add_sum;
    logic signed [olab_pkg::ACC_W-1:0] sat_val;
    logic signed [olab_pkg::ACC_W-1:0] wr_data;
    logic                              wr_en;
    logic                              mem_we;
    logic [olab_pkg::ADDR_W-1:0]       mem_wa;

    // Entry value: bypass the write that lands in the same cycle as the read
    always_comb
    begin
        cur_val = fwd_hit_reg ? fwd_data_reg : rd_reg;
        add_sum = {cur_val[olab_pkg::ACC_W-1], cur_val}
                + (olab_pkg::ACC_W+1)'(s1_reg.sample);
        if (add_sum > $signed({olab_pkg::ACC_MAX[olab_pkg::ACC_W-1], olab_pkg::ACC_MAX}))
            sat_val = olab_pkg::ACC_MAX;
        else if (add_sum < $signed({olab_pkg::ACC_MIN[olab_pkg::ACC_W-1], olab_pkg::ACC_MIN}))
            sat_val = olab_pkg::ACC_MIN;
        else
            sat_val = add_sum[olab_pkg::ACC_W-1:0];
    end

    // Write back: saturated sum for add, zero for pop
    always_comb
    begin
        wr_en   = s1_valid_reg
               && (s1_reg.op == olab_pkg::OP_ADD || s1_reg.op == olab_pkg::OP_POP);
        wr_data = (s1_reg.op == olab_pkg::OP_ADD) ? sat_val : '0;
        mem_we  = clr_busy_reg || wr_en;
        mem_wa  = clr_busy_reg ? clr_addr_reg[olab_pkg::ADDR_W-1:0] : s1_reg.addr;
    end

    // Accumulator memory, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            acc_mem[mem_wa] <= clr_busy_reg ? '0 : wr_data;
        if (issue_valid)
            rd_reg <= acc_mem[issue.addr];
    end

    // Stage payload and bypass data
    always_ff @(posedge clk)
    begin
        if (issue_valid)
        begin
            s1_reg       <= issue;
            fwd_hit_reg  <= wr_en && (s1_reg.addr == issue.addr);
            fwd_data_reg <= wr_data;
        end
    end

    // Clearing pass after reset and stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue_valid;
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + olab_pkg::CLR_W'(1);
                if (clr_addr_reg[olab_pkg::ADDR_W-1:0] == olab_pkg::ADDR_W'(olab_pkg::LENGTH - 1))
                    clr_busy_reg <= 1'b0;
            end
        end
    end

    // Result of the item in this stage
    always_comb
    begin
        res_valid        = s1_valid_reg;
        res.sample_valid = (s1_reg.op == olab_pkg::OP_POP);
        res.sample_out   = (s1_reg.op == olab_pkg::OP_POP) ? cur_val : '0;
        res.filled       = s1_reg.filled;
        res.time_count   = s1_reg.time_count;
    end

    assign clear_busy = clr_busy_reg;

`ifndef NO_ASSERTIONS
    // No request may enter while the memory is being cleared
    assert property (@(posedge clk) disable iff (!rst_n) clr_busy_reg |-> !issue_valid)
        else $error("request accepted during clearing pass");

    // The clearing pass ends only after the last entry
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_busy_reg) |-> $past(clr_addr_reg[olab_pkg::ADDR_W-1:0])
                                == olab_pkg::ADDR_W'(olab_pkg::LENGTH - 1))
        else $error("clearing pass ended early");

    // Only a pop carries a nonzero sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.sample_valid) |-> (res.sample_out == '0))
        else $error("sample on a result that is not a pop");
`endif

endmodule

[rtl/olab_fifo.sv]
module olab_fifo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  olab_pkg::result_t                 push_data,
    input  logic                              pop,
    output logic                              not_empty,
    output olab_pkg::result_t                 head,
    output logic [olab_pkg::FIFO_CNT_W-1:0]   count
);

    olab_pkg::result_t                 fifo_mem [olab_pkg::FIFO_DEPTH];
    logic [olab_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [olab_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [olab_pkg::FIFO_CNT_W-1:0]   cnt_reg;
    logic                              do_pop;

    assign do_pop    = pop && (cnt_reg != '0);
    assign not_empty = (cnt_reg != '0);
    assign head      = fifo_mem[rd_ptr_reg];
    assign count     = cnt_reg;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + olab_pkg::FIFO_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + olab_pkg::FIFO_PTR_W'(1);
            if (push && !do_pop)
                cnt_reg <= cnt_reg + olab_pkg::FIFO_CNT_W'(1);
            else if (!push && do_pop)
                cnt_reg <= cnt_reg - olab_pkg::FIFO_CNT_W'(1);
        end
    end

`ifndef NO_ASSERTIONS
    // The admission rule keeps the queue from overflowing
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |-> (cnt_reg != olab_pkg::FIFO_CNT_W'(olab_pkg::FIFO_DEPTH)))
        else $error("result queue overflow");
`endif

endmodule

[dv/tb_overlap_add_ring_buffer.sv]
`timescale 1ns / 1ps

module tb_overlap_add_ring_buffer;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int ROUND_REQUESTS  = 105;
    localparam int POP_BURST       = 40;

    // Directed plan: plain requests, requests with a hand-written result, threshold writes
    typedef enum logic [1:0] {
        ROW_SEND,
        ROW_CHECK,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t           kind;
        olab_pkg::op_t       op;
        logic [15:0]         smp;   // threshold value on ROW_CFG
        logic [12:0]         hop;
        olab_pkg::result_t   want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_wr_en;
    logic [olab_pkg::THR_W-1:0] cfg_wr_data;

    // Shadow copy of the ring and its pointers
    logic signed [olab_pkg::ACC_W-1:0] acc_ring [olab_pkg::LENGTH];
    logic [olab_pkg::ADDR_W-1:0]       rd_ptr;
    logic signed [olab_pkg::OFS_W-1:0] wr_ofs;
    logic [olab_pkg::FIDX_W-1:0]       frame_pos;
    logic [olab_pkg::TIME_W-1:0]       time_acc;
    logic [olab_pkg::THR_W-1:0]        fill_thr;

    olab_pkg::result_t results_due [$];
    int      requests_sent = 0;
    int      failures = 0;
    logic    no_gaps = 1'b0;
    logic    hold_off_req = 1'b0;

    overlap_add_ring_buffer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #6;
        clk = 1'b1;
        #6;
        clk = 1'b0;
    end

    function automatic int clip(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Applies one request to the shadow ring and returns the result it should produce
    function automatic olab_pkg::result_t ola_step_result(input olab_pkg::op_t op,
                                                          input logic [15:0] smp,
                                                          input logic [12:0] hop);
        olab_pkg::result_t res;
        int                slot;
        int                acc;
        res = '0;
        case (op)
            olab_pkg::OP_ADD:
            begin
                // ring length is a power of two, so masking is the true modulo
                slot = (int'(rd_ptr) + int'(wr_ofs) + int'(frame_pos))
                     & (olab_pkg::LENGTH - 1);
                acc = clip(int'(acc_ring[slot]) + int'($signed(smp)),
                           int'(olab_pkg::ACC_MIN), int'(olab_pkg::ACC_MAX));
                acc_ring[slot] = olab_pkg::ACC_W'(acc);
                frame_pos = frame_pos + 1'b1;
            end
            olab_pkg::OP_END:
            begin
                frame_pos = '0;
                wr_ofs = olab_pkg::OFS_W'(clip(int'(wr_ofs) + int'(hop),
                                               int'(olab_pkg::OFS_MIN),
                                               int'(olab_pkg::OFS_MAX)));
                time_acc = time_acc + olab_pkg::TIME_W'(hop);
            end
            olab_pkg::OP_POP:
            begin
                res.sample_out = acc_ring[rd_ptr];
                acc_ring[rd_ptr] = '0;
                rd_ptr = rd_ptr + 1'b1;
                wr_ofs = olab_pkg::OFS_W'(clip(int'(wr_ofs) - 1, int'(olab_pkg::OFS_MIN),
                                               int'(olab_pkg::OFS_MAX)));
            end
            default:
            begin
            end
        endcase
        res.sample_valid = (op == olab_pkg::OP_POP);
        res.filled       = (int'(wr_ofs) > int'(fill_thr));
        res.time_count   = time_acc;
        return res;
    endfunction

    function automatic plan_row_t send_row(input olab_pkg::op_t op, input logic [15:0] smp,
                                           input logic [12:0] hop);
        plan_row_t row;
        row.kind = ROW_SEND;
        row.op   = op;
        row.smp  = smp;
        row.hop  = hop;
        row.want = '0;
        return row;
    endfunction

    function automatic plan_row_t check_row(input olab_pkg::op_t op, input logic [15:0] smp,
                                            input logic [12:0] hop, input int out,
                                            input logic filled, input int unsigned tc);
        plan_row_t row;
        row = send_row(op, smp, hop);
        row.kind              = ROW_CHECK;
        row.want.sample_out   = out[olab_pkg::ACC_W-1:0];
        row.want.sample_valid = (op == olab_pkg::OP_POP);
        row.want.filled       = filled;
        row.want.time_count   = tc;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input logic [15:0] value);
        plan_row_t row;
        row = send_row(olab_pkg::OP_NOP, value, '0);
        row.kind = ROW_CFG;
        return row;
    endfunction

    // Offer one request, wait for acceptance, queue its expected result
    task automatic push_request(input plan_row_t row);
        olab_pkg::result_t predicted;
        while (!no_gaps && $urandom_range(0, 99) < 11)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= row.op;
        s_tdata  <= {3'b000, row.hop, row.smp};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = ola_step_result(row.op, row.smp, row.hop);
        results_due.push_back(row.kind == ROW_CHECK ? row.want : predicted);
        requests_sent++;
    endtask

    // Stop offering and wait until every queued result has come back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_threshold(input logic [15:0] value);
        drain_results();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        fill_thr = value;
    endtask

    task automatic flag_mismatch(input string field, input longint want, input longint got);
        failures++;
        $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        olab_pkg::result_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (results_due.size() == 0)
            begin
                failures++;
                $error("result with no request outstanding");
            end
            else
            begin
                want = results_due.pop_front();
                if (m_tdata[23:0] !== want.sample_out)
                    flag_mismatch("sample_out", longint'(want.sample_out),
                                  longint'($signed(m_tdata[23:0])));
                if (m_tuser !== want.sample_valid)
                    flag_mismatch("sample_valid", longint'(want.sample_valid),
                                  longint'(m_tuser));
                if (m_tdata[24] !== want.filled)
                    flag_mismatch("filled", longint'(want.filled), longint'(m_tdata[24]));
                if (m_tdata[56:25] !== want.time_count)
                    flag_mismatch("time_count", longint'(want.time_count),
                                  longint'(m_tdata[56:25]));
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin : sink
        logic hold_off_done;
        hold_off_done = 1'b0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES)
                    @(negedge clk);
                hold_off_done = 1'b1;
            end
            m_tready <= (no_gaps || $urandom_range(0, 99) >= 11);
        end
    end

    initial
    begin : stimulus
        plan_row_t   plan [$];
        int          goal;
        int          pick;
        int          n;
        int          round;
        logic [12:0] hop;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = olab_pkg::OP_NOP;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        foreach (acc_ring[i])
            acc_ring[i] = '0;
        rd_ptr    = '0;
        wr_ofs    = '0;
        frame_pos = '0;
        time_acc  = '0;
        fill_thr  = '0;

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_threshold(16'd0);

        // Directed: empty pop, extremes, long hops, offset clamp, threshold edges
        plan.push_back(check_row(olab_pkg::OP_POP, 16'($urandom), 13'($urandom),
                                 0, 1'b0, 0));
        plan.push_back(check_row(olab_pkg::OP_NOP, 16'hFFFF, 13'h1FFF, 0, 1'b0, 0));
        plan.push_back(check_row(olab_pkg::OP_ADD, 16'h7FFF, 13'h1FFF, 0, 1'b0, 0));
        plan.push_back(check_row(olab_pkg::OP_ADD, 16'h8000, 13'd0, 0, 1'b0, 0));
        plan.push_back(check_row(olab_pkg::OP_ADD, 16'hFFFF, 13'd0, 0, 1'b0, 0));
        plan.push_back(check_row(olab_pkg::OP_END, 16'hFFFF, 13'd0, 0, 1'b0, 0));
        plan.push_back(check_row(olab_pkg::OP_ADD, 16'h7FFF, 13'd0, 0, 1'b0, 0));
        plan.push_back(check_row(olab_pkg::OP_END, 16'h0000, 13'h1FFF, 0, 1'b1, 8191));
        plan.push_back(check_row(olab_pkg::OP_END, 16'h0000, 13'd4096, 0, 1'b1, 12287));
        plan.push_back(check_row(olab_pkg::OP_END, 16'h0000, 13'd4097, 0, 1'b1, 16384));
        plan.push_back(send_row(olab_pkg::OP_ADD, 16'h5A5A, 13'h0AAA));
        repeat (6)
            plan.push_back(send_row(olab_pkg::OP_END, 16'($urandom), 13'h1FFF));
        // offset clamps at its positive limit here
        plan.push_back(check_row(olab_pkg::OP_END, 16'h0000, 13'h1FFF, 0, 1'b1, 73721));
        plan.push_back(cfg_row(16'hFFFF));
        plan.push_back(check_row(olab_pkg::OP_NOP, 16'h0000, 13'h0000, 0, 1'b0, 73721));
        plan.push_back(cfg_row(16'hFFFE));
        plan.push_back(check_row(olab_pkg::OP_NOP, 16'h0000, 13'h0000, 0, 1'b1, 73721));
        plan.push_back(check_row(olab_pkg::OP_POP, 16'h1234, 13'h1555,
                                 -32768, 1'b0, 73721));
        plan.push_back(check_row(olab_pkg::OP_POP, 16'h0000, 13'h0000, -1, 1'b0, 73721));
        plan.push_back(send_row(olab_pkg::OP_ADD, 16'h8001, 13'h1555));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                set_threshold(plan[i].smp);
            else
                push_request(plan[i]);
        end

        // Pop burst with no idling on either side
        no_gaps = 1'b1;
        repeat (POP_BURST)
            push_request(send_row(olab_pkg::OP_POP, 16'($urandom), 13'($urandom)));
        no_gaps = 1'b0;

        // A short frame, then climb back to the offset limit
        repeat (6)
            push_request(send_row(olab_pkg::OP_ADD, 16'($urandom), 13'($urandom)));
        repeat (8)
            push_request(send_row(olab_pkg::OP_END, 16'($urandom), 13'h1FFF));

        // Random frames, pop bursts and noise under several thresholds
        for (round = 0; round < 4; round++)
        begin
            case (round)
                0: set_threshold(16'd0);
                1: set_threshold(16'($urandom_range(1, 64)));
                2: set_threshold(16'hFFFF);
                default: set_threshold(16'($urandom));
            endcase
            if (round == 0)
                hold_off_req = 1'b1;
            goal = requests_sent + ROUND_REQUESTS;
            while (requests_sent < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    // one frame; now and then left unterminated
                    n = $urandom_range(1, 40);
                    repeat (n)
                        push_request(send_row(olab_pkg::OP_ADD, 16'($urandom),
                                              13'($urandom)));
                    if ($urandom_range(0, 9) != 0)
                        push_request(send_row(olab_pkg::OP_END, 16'($urandom),
                                              13'($urandom_range(0, n))));
                end
                else if (pick < 85)
                begin
                    repeat ($urandom_range(1, 24))
                        push_request(send_row(olab_pkg::OP_POP, 16'($urandom),
                                              13'($urandom)));
                end
                else
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        hop = ($urandom_range(0, 31) == 0) ? 13'($urandom)
                                                           : 13'($urandom_range(0, 15));
                        push_request(send_row(olab_pkg::op_t'($urandom_range(0, 3)),
                                              16'($urandom), hop));
                    end
                end
            end
        end

        drain_results();
        repeat (8)
            @(posedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin : watchdog
        #(50_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
